FILE: sv/isoepd_pkg.sv
package isoepd_pkg;

  // Depth of the queue between the character front end and the date back end.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Number of characters in a complete date string.
  localparam logic [3:0] DATE_LEN = 4'd10;

  // Character codes used by the parser.
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Day number of 1970-01-01 in the March-based era count, plus one era,
  // because the back end carries the era count offset by one.
  localparam logic [23:0] EPOCH_BIAS = 24'd865565;
  localparam logic [21:0] ERA_DAYS   = 22'd146097;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FORMAT    = 3'd1,
    STS_MONTH     = 3'd2,
    STS_DAY       = 3'd3,
    STS_DAY_MONTH = 3'd4
  } status_e;

  // One parsed date string as handed from the front end to the back end.
  typedef struct packed {
    logic        fmt_bad;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } rec_t;

  // Length of a month (1 to 12), with February stretched in leap years.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first day of the month, in the March-based year.
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] offs;
    offs = 9'd0;
    unique case (month)
      4'd1:    offs = 9'd306;
      4'd2:    offs = 9'd337;
      4'd3:    offs = 9'd0;
      4'd4:    offs = 9'd31;
      4'd5:    offs = 9'd61;
      4'd6:    offs = 9'd92;
      4'd7:    offs = 9'd122;
      4'd8:    offs = 9'd153;
      4'd9:    offs = 9'd184;
      4'd10:   offs = 9'd214;
      4'd11:   offs = 9'd245;
      4'd12:   offs = 9'd275;
      default: offs = 9'd0;
    endcase
    return offs;
  endfunction

endpackage

FILE: sv/isoepd_front.sv
module isoepd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               rec_push_o,
  output isoepd_pkg::rec_t   rec_o
);

  logic [3:0]  pos_q,   pos_d;
  logic [13:0] year_q,  year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q,   day_d;
  logic        bad_q,   bad_d;

  logic        is_digit;
  logic [3:0]  digit;

  assign is_digit = (char_code_i >= isoepd_pkg::CHAR_ZERO) &&
                    (char_code_i <= isoepd_pkg::CHAR_NINE);
  assign digit    = 4'(char_code_i - isoepd_pkg::CHAR_ZERO);

  // Classify the character at the current position and fold digits in.
  always_comb begin
    pos_d   = pos_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    bad_d   = bad_q;
    if (pos_q < isoepd_pkg::DATE_LEN) begin
      if (pos_q == 4'd4 || pos_q == 4'd7) begin
        if (char_code_i != isoepd_pkg::CHAR_HYPHEN) begin
          bad_d = 1'b1;
        end
      end else if (!is_digit) begin
        bad_d = 1'b1;
      end else if (pos_q < 4'd4) begin
        year_d = 14'(year_q * 14'd10 + {10'd0, digit});
      end else if (pos_q < 4'd7) begin
        month_d = 7'(month_q * 7'd10 + {3'd0, digit});
      end else begin
        day_d = 7'(day_q * 7'd10 + {3'd0, digit});
      end
      pos_d = pos_q + 4'd1;
    end
  end

  // The final character closes the string and hands it to the queue.
  assign rec_push_o    = accept_i && last_char_i;
  assign rec_o.fmt_bad = bad_d || (pos_d < isoepd_pkg::DATE_LEN);
  assign rec_o.year    = year_d;
  assign rec_o.month   = month_d;
  assign rec_o.day     = day_d;

  // Parser state returns to its reset value after every string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_char_i) begin
        pos_q   <= '0;
        year_q  <= '0;
        month_q <= '0;
        day_q   <= '0;
        bad_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        year_q  <= year_d;
        month_q <= month_d;
        day_q   <= day_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

FILE: sv/isoepd_fifo.sv
module isoepd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  isoepd_pkg::rec_t   rec_i,
  output logic               full_o,
  input  logic               pop_i,
  output isoepd_pkg::rec_t   rec_o,
  output logic               empty_o
);

  localparam int unsigned CW = $clog2(isoepd_pkg::QDEPTH + 1);

  isoepd_pkg::rec_t         mem_q [isoepd_pkg::QDEPTH];
  logic [isoepd_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]            count_q;

  assign full_o  = (count_q == CW'(isoepd_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign rec_o   = mem_q[rd_ptr_q];

  // Storage words are written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == isoepd_pkg::QAW'(isoepd_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == isoepd_pkg::QAW'(isoepd_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/isoepd_back.sv
module isoepd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isoepd_pkg::rec_t    rec_i,
  input  logic                rec_empty_i,
  output logic                rec_pop_o,
  output logic signed [22:0]  epoch_days_o,
  output logic [2:0]          status_o,
  output logic                empty_o,
  input  logic                pop_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_REM  = 5'b00100,
    S_DOE  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  isoepd_pkg::rec_t      rec_q;
  logic [13:0]           t_q;
  logic [4:0]            era1_q;
  logic [6:0]            q100_q;
  logic [8:0]            yoe_q;
  logic                  leap_q;
  isoepd_pkg::status_e   sts_q, sts_d;
  logic [17:0]           doe_q, doe_d;
  logic signed [22:0]    out_days_q;
  isoepd_pkg::status_e   out_sts_q;
  logic                  out_valid_q;

  logic                  out_free;
  logic                  load_out;
  logic                  month_le2;
  logic [13:0]           t_d;
  logic [15:0]           era_prod;
  logic [23:0]           q100_prod;
  logic [13:0]           rem100_full;
  logic [6:0]            rem100;
  logic                  leap_d;
  logic [13:0]           yoe_full;
  logic [12:0]           yoe100_prod;
  logic [4:0]            max_day;
  logic [21:0]           era_days;
  logic [23:0]           days_sum;

  assign out_free  = !out_valid_q || pop_i;
  assign load_out  = (state_q == S_FIN) && out_free;
  assign rec_pop_o = (state_q == S_IDLE) && !rec_empty_i;

  // Sequencer: take a record, divide, take remainders, day of era, final sum.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (!rec_empty_i) state_d = S_DIV;
      S_DIV:   state_d = S_REM;
      S_REM:   state_d = S_DOE;
      S_DOE:   state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Quotients by 400 and by 100 come from reciprocal multiplies.
  assign month_le2 = (rec_q.month <= 7'd2);
  assign t_d       = rec_q.year + 14'd400 - {13'd0, month_le2};
  assign era_prod  = {6'd0, t_d[13:4]} * 16'd41;
  assign q100_prod = {12'd0, rec_q.year[13:2]} * 24'd2622;

  // Remainders give the year of era and the leap year flag.
  assign rem100_full = rec_q.year - {7'd0, q100_q} * 14'd100;
  assign rem100      = rem100_full[6:0];
  assign leap_d      = (rec_q.year[1:0] == 2'd0) &&
                       ((rem100 != 7'd0) || (q100_q[1:0] == 2'd0));
  assign yoe_full    = t_q - {9'd0, era1_q} * 14'd400;

  // Range checks in priority order, and the day of the era.
  assign max_day     = isoepd_pkg::month_len(rec_q.month[3:0], leap_q);
  assign yoe100_prod = {6'd0, yoe_q[8:2]} * 13'd41;

  always_comb begin
    if (rec_q.fmt_bad) begin
      sts_d = isoepd_pkg::STS_FORMAT;
    end else if (rec_q.month < 7'd1 || rec_q.month > 7'd12) begin
      sts_d = isoepd_pkg::STS_MONTH;
    end else if (rec_q.day < 7'd1 || rec_q.day > 7'd31) begin
      sts_d = isoepd_pkg::STS_DAY;
    end else if (rec_q.day > {2'd0, max_day}) begin
      sts_d = isoepd_pkg::STS_DAY_MONTH;
    end else begin
      sts_d = isoepd_pkg::STS_OK;
    end
    doe_d = {9'd0, yoe_q} * 18'd365 + {11'd0, yoe_q[8:2]} - {15'd0, yoe100_prod[12:10]}
            + {9'd0, isoepd_pkg::month_offset(rec_q.month[3:0])}
            + {11'd0, rec_q.day} - 18'd1;
  end

  // Era count is carried plus one; the bias takes that era back out.
  assign era_days = {17'd0, era1_q} * isoepd_pkg::ERA_DAYS;
  assign days_sum = {2'd0, era_days} + {6'd0, doe_q} - isoepd_pkg::EPOCH_BIAS;

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      rec_q <= rec_i;
    end
    if (state_q == S_DIV) begin
      t_q    <= t_d;
      era1_q <= era_prod[14:10];
      q100_q <= q100_prod[22:16];
    end
    if (state_q == S_REM) begin
      yoe_q  <= yoe_full[8:0];
      leap_q <= leap_d;
    end
    if (state_q == S_DOE) begin
      sts_q <= sts_d;
      doe_q <= doe_d;
    end
    if (load_out) begin
      out_sts_q  <= sts_q;
      out_days_q <= (sts_q == isoepd_pkg::STS_OK) ? signed'(days_sum[22:0]) : '0;
    end
  end

  // Sequencer state and the result word's valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign epoch_days_o = out_days_q;
  assign status_o     = out_sts_q;

  // A failed check always reports zero days.
  a_err_zero_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sts_q != isoepd_pkg::STS_OK) |-> (out_days_q == '0))
    else $error("nonzero day count with an error status");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_sts_q <= isoepd_pkg::STS_DAY_MONTH))
    else $error("undefined status code in the result word");

  // Taking a record from the queue always starts the division step.
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o |=> (state_q == S_DIV))
    else $error("record taken without starting the sequence");

  // A finished date always lands in the result register.
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && state_q == S_IDLE))
    else $error("result word lost on completion");

endmodule

FILE: sv/iso_date_to_epoch_days_core.sv
// ISO date text to epoch day converter.
// Input channel: one ASCII character a word on char_code_i, with last_char_i
// high on the final character of a string. A word is taken at a clock edge
// with push high and full low. Characters at positions 4 and 7 must be
// hyphens, the others digits; characters past position 9 are ignored.
// Result channel: one word per string, epoch_days_o (signed days since
// 1970-01-01, zero on error) and status_o (0 ok, 1 format, 2 month,
// 3 day outside 1-31, 4 day beyond the month). It is valid while empty is
// low and is taken at a clock edge with pop high.
// Throughput: one character a cycle while full is low. The date arithmetic
// runs per string in a sequencer (take, divide, remainders, day of era,
// final sum) behind a two-word queue, so strings of five or more characters
// stream without stalls; shorter strings are limited by that sequencer.
// The sequencer takes a new string only after loading the last one's result.
// Reset clears the parser, the queue and the result word; no result waits.
// When the receiver stalls, the result word holds, the sequencer waits on its
// last step, the queue fills and full then stops the character stream.
module iso_date_to_epoch_days_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [22:0] epoch_days_o,
  output logic [2:0]         status_o
);

  logic                rec_push;
  logic                rec_pop;
  logic                rec_full;
  logic                rec_empty;
  logic                accept;
  isoepd_pkg::rec_t    rec_in;
  isoepd_pkg::rec_t    rec_out;

  assign full   = rec_full;
  assign accept = push && !rec_full;

  // Character parser.
  isoepd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  // Queue of parsed strings.
  isoepd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rec_o   (rec_out),
    .empty_o (rec_empty)
  );

  // Date checks and day count.
  isoepd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (rec_out),
    .rec_empty_i  (rec_empty),
    .rec_pop_o    (rec_pop),
    .epoch_days_o (epoch_days_o),
    .status_o     (status_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule
